// ----- sv/bmpp_pkg.sv -----
// shared types and constants of the bmp 24-bit stream parser
`default_nettype none

package bmpp_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam logic [15:0] SIG_BM   = 16'h4D42;
	localparam logic [31:0] DIB_SIZE = 32'd40;
	localparam logic [15:0] PLANES_1 = 16'd1;
	localparam logic [15:0] BPP_24   = 16'd24;

	localparam logic [5:0] HB_SIG     = 6'd1;
	localparam logic [5:0] HB_DIB     = 6'd17;
	localparam logic [5:0] HB_WIDTH   = 6'd21;
	localparam logic [5:0] HB_HEIGHT  = 6'd25;
	localparam logic [5:0] HB_PLANES  = 6'd27;
	localparam logic [5:0] HB_BPP     = 6'd29;
	localparam logic [5:0] HB_COLORS  = 6'd49;
	localparam logic [5:0] HB_END     = 6'd53;

	localparam logic [2:0] ST_PIXEL    = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_BAD_SIG  = 3'd2;
	localparam logic [2:0] ST_BAD_DIB  = 3'd3;
	localparam logic [2:0] ST_BAD_PLN  = 3'd4;
	localparam logic [2:0] ST_BAD_BPP  = 3'd5;
	localparam logic [2:0] ST_PALETTE  = 3'd6;
	localparam logic [2:0] ST_TOO_BIG  = 3'd7;

	localparam int TDATA_W = 48;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] column;
		logic [11:0] row;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last;
	} pix_result_t;

endpackage

`default_nettype wire

// ----- sv/bmp_24bit_stream_parser.sv -----
// top level of the bmp 24-bit stream parser
//
// channel  dir  tdata                      tuser        tlast
// s_       in   data_byte[7:0]             first_byte   -
// m_       out  column,row,red,green,blue  status[2:0]  last
//
// one file byte is taken per cycle, back to back, while s_tready is high
// a result word appears in the cycle after the byte that completes it
// the single result register decouples both sides; s_tready drops only
// while that register is full and m_tready is low
// arst_n clears the parser to idle; bytes before a first_byte are dropped
`default_nettype none

module bmp_24bit_stream_parser import bmpp_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,  // data_byte
	input  wire logic               s_tuser,  // first_byte
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,  // column, row, red, green, blue
	output logic [2:0]              m_tuser,  // status
	output logic                    m_tlast
);

	logic        accept;
	logic        res_valid;
	pix_result_t res;
	pix_result_t out_res;

	assign accept = s_tvalid && s_tready;

	bmpp_parse #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (s_tdata),
		.first_byte (s_tuser),
		.res        (res),
		.res_valid  (res_valid)
	);

	bmpp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.ready     (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.blue, out_res.green, out_res.red, out_res.row, out_res.column};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// ----- sv/bmpp_parse.sv -----
// header field checks, pixel assembly and row counters
`default_nettype none

module bmpp_parse import bmpp_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	output pix_result_t      res,
	output logic             res_valid
);

	localparam int WW = $clog2(MAX_WIDTH + 2);
	localparam int HW = $clog2(MAX_HEIGHT + 2);
	localparam int WIDTH_HUGE  = MAX_WIDTH + 1;
	localparam int HEIGHT_HUGE = MAX_HEIGHT + 1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_d, phase_cur;
	logic [5:0]  cnt_q, cnt_d, cnt_cur;
	logic [31:0] shift_q, shift_d, shift_cur, shift_new;
	logic [WW-1:0] width_q, width_d;
	logic [HW-1:0] height_q, height_d;
	logic [WW-1:0] col_q, col_d, col_next;
	logic [HW-1:0] row_q, row_d, row_next;
	logic [1:0]  color_q, color_d;
	logic [7:0]  blue_q, blue_d;
	logic [7:0]  green_q, green_d;
	logic [1:0]  pad_q, pad_d;
	logic        fail;
	logic [2:0]  fail_status;

	assign shift_new = {data_byte, shift_cur[31:8]};
	assign col_next  = col_q + 1'b1;
	assign row_next  = row_q + 1'b1;

	always_comb begin
		phase_cur   = phase_q;
		cnt_cur     = cnt_q;
		shift_cur   = shift_q;
		if (first_byte) begin
			phase_cur = PH_HEADER;
			cnt_cur   = '0;
			shift_cur = '0;
		end
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		shift_d     = shift_q;
		width_d     = width_q;
		height_d    = height_q;
		col_d       = col_q;
		row_d       = row_q;
		color_d     = color_q;
		blue_d      = blue_q;
		green_d     = green_q;
		pad_d       = pad_q;
		fail        = 1'b0;
		fail_status = ST_PIXEL;
		res         = '0;
		res_valid   = 1'b0;
		if (accept) begin
			phase_d = phase_cur;
			cnt_d   = cnt_cur;
			shift_d = shift_cur;
			case (phase_cur)
				PH_HEADER: begin
					shift_d = shift_new;
					cnt_d   = cnt_cur + 1'b1;
					case (cnt_cur)
						HB_SIG: begin
							if (shift_new[31:16] != SIG_BM) begin
								fail = 1'b1; fail_status = ST_BAD_SIG;
							end
						end
						HB_DIB: begin
							if (shift_new != DIB_SIZE) begin
								fail = 1'b1; fail_status = ST_BAD_DIB;
							end
						end
						HB_WIDTH: begin
							if (shift_new[31] || shift_new > 32'(MAX_WIDTH))
								width_d = WW'(WIDTH_HUGE);
							else
								width_d = WW'(shift_new);
						end
						HB_HEIGHT: begin
							if (shift_new[31] || shift_new > 32'(MAX_HEIGHT))
								height_d = HW'(HEIGHT_HUGE);
							else
								height_d = HW'(shift_new);
						end
						HB_PLANES: begin
							if (shift_new[31:16] != PLANES_1) begin
								fail = 1'b1; fail_status = ST_BAD_PLN;
							end
						end
						HB_BPP: begin
							if (shift_new[31:16] != BPP_24) begin
								fail = 1'b1; fail_status = ST_BAD_BPP;
							end
						end
						HB_COLORS: begin
							if (shift_new != '0) begin
								fail = 1'b1; fail_status = ST_PALETTE;
							end
						end
						HB_END: begin
							if (width_q > WW'(MAX_WIDTH) || height_q > HW'(MAX_HEIGHT)) begin
								fail = 1'b1; fail_status = ST_TOO_BIG;
							end else if (width_q == '0 || height_q == '0) begin
								fail = 1'b1; fail_status = ST_EMPTY;
							end else begin
								phase_d = PH_PIXELS;
								col_d   = '0;
								row_d   = '0;
								color_d = '0;
								pad_d   = '0;
							end
						end
						default: begin
						end
					endcase
					if (fail) begin
						phase_d       = PH_DONE;
						res_valid     = 1'b1;
						res.status    = fail_status;
						res.last      = 1'b1;
					end
				end
				PH_PIXELS: begin
					if (pad_q != '0) begin
						pad_d = pad_q - 1'b1;
					end else if (color_q == 2'd0) begin
						blue_d  = data_byte;
						color_d = 2'd1;
					end else if (color_q == 2'd1) begin
						green_d = data_byte;
						color_d = 2'd2;
					end else begin
						color_d    = 2'd0;
						res_valid  = 1'b1;
						res.status = ST_PIXEL;
						res.column = 12'(col_q);
						res.row    = 12'(row_q);
						res.red    = data_byte;
						res.green  = green_q;
						res.blue   = blue_q;
						if (col_next >= width_q) begin
							if (row_next >= height_q) begin
								res.last = 1'b1;
								phase_d  = PH_DONE;
							end else begin
								col_d = '0;
								row_d = row_next;
								// padding length equals width mod 4
								pad_d = width_q[1:0];
							end
						end else begin
							col_d = col_next;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			shift_q  <= '0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			color_q  <= '0;
			blue_q   <= '0;
			green_q  <= '0;
			pad_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			shift_q  <= shift_d;
			width_q  <= width_d;
			height_q <= height_d;
			col_q    <= col_d;
			row_q    <= row_d;
			color_q  <= color_d;
			blue_q   <= blue_d;
			green_q  <= green_d;
			pad_q    <= pad_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/bmpp_out_reg.sv -----
// result register between the parser and the output stream
`default_nettype none

module bmpp_out_reg import bmpp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire pix_result_t in_res,
	output logic             ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output pix_result_t      out_res
);

	logic        valid_q;
	pix_result_t res_q;

	assign ready     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
		end else if (ready) begin
			valid_q <= in_valid;
			if (in_valid) begin
				res_q <= in_res;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/bmpp_checker.sv -----
// port checker for the bmp 24-bit stream parser and its bind
`default_nettype none

module bmpp_checker import bmpp_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata,
	input wire logic [2:0]         m_tuser,
	input wire logic               m_tlast
);

	// a held word keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// status words end the file and carry no pixel
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_PIXEL |-> m_tlast && m_tdata == '0)
		else $error("status word without last or with pixel data");

	// empty result register never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a new word only follows an accepted byte
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("output word without input byte");

endmodule

bind bmp_24bit_stream_parser bmpp_checker u_bmpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
